/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

/* src/dcc_pkg.sv */
// ---------------------------------------------------------------------------
// dcc_pkg
// Constants, types and the month table of the day count converter.
// ---------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

  localparam int DAY_COUNT_W   = 16;
  localparam int YEAR_W        = 8;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int CYCLE_W       = 6;   // four-year cycle count, at most 44
  localparam int REM_W         = 12;  // remainder before correction, below 2922
  localparam int DOY_W         = 9;   // day of year, below 366

  localparam int DAYS_PER_CYCLE  = 1461;
  localparam int DAYS_LEAP_YEAR  = 366;
  localparam int DAYS_PLAIN_YEAR = 365;
  localparam int YEAR1_START     = DAYS_LEAP_YEAR;
  localparam int YEAR2_START     = YEAR1_START + DAYS_PLAIN_YEAR;
  localparam int YEAR3_START     = YEAR2_START + DAYS_PLAIN_YEAR;

  // floor(2^22 / 1461): the estimate is exact or one low over 16-bit counts
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 12;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DAYS_PER_CYCLE;
  localparam int PROD_W      = DAY_COUNT_W + RECIP_W;

  localparam int MONTHS = 12;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  localparam int MAX_YEAR_OFFSET = 179;
  localparam int MAX_DAY         = 30;

  typedef struct packed {
    logic [YEAR_W-1:0] year_offset;
    logic              leap;
    logic [DOY_W-1:0]  day_of_year;
  } year_date_t;

  // First day of each month within the year; one more from March in a leap year.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    logic [DOY_W-1:0] extra;
    case (month)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    extra = (leap && (month > MONTH_FEB)) ? 9'd1 : 9'd0;
    return base + extra;
  endfunction

endpackage

`default_nettype wire

/* src/dcc_req_if.sv */
// ---------------------------------------------------------------------------
// dcc_req_if
// Request channel: a day count with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface dcc_req_if
  import dcc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [DAY_COUNT_W-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

`default_nettype wire

/* src/dcc_res_if.sv */
// ---------------------------------------------------------------------------
// dcc_res_if
// Result channel: year offset, month and day with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface dcc_res_if
  import dcc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_offset;
  logic [MONTH_W-1:0] month_index;
  logic [DAY_W-1:0]   day_of_month;

  modport source (output valid, output year_offset, output month_index,
                  output day_of_month, input ready);
  modport sink   (input valid, input year_offset, input month_index,
                  input day_of_month, output ready);
endinterface

`default_nettype wire

/* src/dcc_divide.sv */
// ---------------------------------------------------------------------------
// dcc_divide
// Three stages: reciprocal multiply, remainder, then correction and year split.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcc_divide
  import dcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  dcc_req_if.sink         request,
  output logic            yd_valid,
  input  wire logic       yd_ready,
  output year_date_t      yd
);

  logic                   v1, v2, v3;
  logic                   ready1, ready2, ready3;
  logic [DAY_COUNT_W-1:0] day1;
  logic [CYCLE_W-1:0]     quot1, quot2;
  logic [REM_W-1:0]       rem2;
  year_date_t             yd3;

  logic [PROD_W-1:0]      recip_prod;
  logic [DAY_COUNT_W:0]   cycle_days;
  logic [DAY_COUNT_W:0]   rem_full;
  logic                   over;
  logic [REM_W-1:0]       rem_fix;
  logic [CYCLE_W-1:0]     quot_fix;
  logic [1:0]             year_in_cycle;
  logic [REM_W-1:0]       year_base;
  logic [REM_W-1:0]       doy_wide;
  year_date_t             yd3_next;

  assign ready3 = !v3 || yd_ready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign request.ready = ready1;

  // Stage 1: quotient estimate by reciprocal multiply
  assign recip_prod = PROD_W'(request.day_count) * PROD_W'(RECIP);

  // Stage 2: remainder against the estimate, below twice the cycle length
  assign cycle_days = (DAY_COUNT_W+1)'(quot1) * (DAY_COUNT_W+1)'(DAYS_PER_CYCLE);
  assign rem_full   = (DAY_COUNT_W+1)'(day1) - cycle_days;

  // Stage 3: fold the estimate error, then split the cycle into years
  always_comb begin
    over     = rem2 >= REM_W'(DAYS_PER_CYCLE);
    rem_fix  = over ? (rem2 - REM_W'(DAYS_PER_CYCLE)) : rem2;
    quot_fix = over ? (quot2 + CYCLE_W'(1)) : quot2;
    if (rem_fix < REM_W'(YEAR1_START)) begin
      year_in_cycle = 2'd0;
      year_base     = '0;
    end else if (rem_fix < REM_W'(YEAR2_START)) begin
      year_in_cycle = 2'd1;
      year_base     = REM_W'(YEAR1_START);
    end else if (rem_fix < REM_W'(YEAR3_START)) begin
      year_in_cycle = 2'd2;
      year_base     = REM_W'(YEAR2_START);
    end else begin
      year_in_cycle = 2'd3;
      year_base     = REM_W'(YEAR3_START);
    end
    doy_wide = rem_fix - year_base;
    yd3_next.year_offset = {quot_fix, 2'b00} + YEAR_W'(year_in_cycle);
    yd3_next.leap        = (year_in_cycle == 2'd0);
    yd3_next.day_of_year = doy_wide[DOY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= request.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && request.valid) begin
      day1  <= request.day_count;
      quot1 <= recip_prod[RECIP_SHIFT +: CYCLE_W];
    end
    if (ready2 && v1) begin
      quot2 <= quot1;
      rem2  <= rem_full[REM_W-1:0];
    end
    if (ready3 && v2) begin
      yd3 <= yd3_next;
    end
  end

  assign yd_valid = v3;
  assign yd       = yd3;

  `ASSERT_IMPLIES(a_rem_bound, clk, rst, v2, rem_full[DAY_COUNT_W:REM_W] == '0 && rem2 < REM_W'(2 * DAYS_PER_CYCLE))
  `ASSERT_IMPLIES(a_year_range, clk, rst, v3, yd3.year_offset <= YEAR_W'(MAX_YEAR_OFFSET) && yd3.day_of_year < DOY_W'(DAYS_LEAP_YEAR))

endmodule

`default_nettype wire

/* src/dcc_month.sv */
// ---------------------------------------------------------------------------
// dcc_month
// Two stages: month search over the start table, then day-of-month subtract.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcc_month
  import dcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       yd_valid,
  output logic            yd_ready,
  input  wire year_date_t yd,
  dcc_res_if.source       result
);

  logic                v4, v5;
  logic                ready4, ready5;
  logic [MONTH_W-1:0]  month4;
  year_date_t          yd4;
  logic [YEAR_W-1:0]   year5;
  logic [MONTH_W-1:0]  month5;
  logic [DAY_W-1:0]    day5;

  logic [MONTHS-1:1]   past_start;
  logic [MONTH_W-1:0]  month_count;
  logic [DOY_W-1:0]    start4;
  logic [DOY_W-1:0]    day_wide;

  assign ready5   = !v5 || result.ready;
  assign ready4   = !v4 || ready5;
  assign yd_ready = ready4;

  // Stage 4: count month starts already reached
  always_comb begin
    month_count = '0;
    for (int i = 1; i < MONTHS; i++) begin
      past_start[i] = yd.day_of_year >= month_start(MONTH_W'(i), yd.leap);
      month_count   = month_count + MONTH_W'(past_start[i]);
    end
  end

  // Stage 5: offset within the month
  assign start4   = month_start(month4, yd4.leap);
  assign day_wide = yd4.day_of_year - start4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready4) v4 <= yd_valid;
      if (ready5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && yd_valid) begin
      yd4    <= yd;
      month4 <= month_count;
    end
    if (ready5 && v4) begin
      year5  <= yd4.year_offset;
      month5 <= month4;
      day5   <= day_wide[DAY_W-1:0];
    end
  end

  assign result.valid        = v5;
  assign result.year_offset  = year5;
  assign result.month_index  = month5;
  assign result.day_of_month = day5;

  `ASSERT_IMPLIES(a_month_start, clk, rst, v4, yd4.day_of_year >= start4 && day_wide <= DOY_W'(MAX_DAY))
  `ASSERT_IMPLIES(a_out_range, clk, rst, v5, month5 <= MONTH_DEC && day5 <= DAY_W'(MAX_DAY))

endmodule

`default_nettype wire

/* src/day_count_to_calendar_date.sv */
// Throughput: one request per cycle; a stalled result holds every occupied stage.
// Depth is set by the two multiplies (reciprocal estimate, remainder), the
// year correction, the month start compare bank and the day subtract.
// Reset clears the stage valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
// day_count_to_calendar_date
// Converts days since 1 January 1980 into year offset, month and day of month
// with the every-fourth-year leap rule.
// ---------------------------------------------------------------------------
`default_nettype none

module day_count_to_calendar_date
  import dcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dcc_req_if.sink   request,
  dcc_res_if.source result
);

  // Link between the year split and the month search
  logic       yd_valid;
  logic       yd_ready;
  year_date_t yd;

  // Stages 1-3: divide by the four-year cycle, correct, split into years
  dcc_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .yd_valid (yd_valid),
    .yd_ready (yd_ready),
    .yd       (yd)
  );

  // Stages 4-5: find the month, then the day within it; stage 5 is the
  // output register; while a result waits, requests are taken only until the stages fill
  dcc_month u_month (
    .clk      (clk),
    .rst      (rst),
    .yd_valid (yd_valid),
    .yd_ready (yd_ready),
    .yd       (yd),
    .result   (result)
  );

endmodule

`default_nettype wire
